// ----- rtl/fmtpg_pkg.sv -----
// ----------------------------------------------------------------------------
// Fader and mute test pattern generator package
// Shared sizes, register map, reset values and arithmetic helpers.
// ----------------------------------------------------------------------------
package fmtpg_pkg;

  // Channel counts, each from 1 to 32.
  localparam int FADER_COUNT = 16;
  localparam int MUTE_COUNT  = 16;

  // Fader ramp memory addressing.
  localparam int FADER_AW = (FADER_COUNT > 1) ? $clog2(FADER_COUNT) : 1;

  // Results per item and the slot counter that walks all channels.
  localparam int MAX_RESULTS = 32;
  localparam int SLOT_W      = 7;

  // Configuration port.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_FADER_PERIOD = 2'd0;
  localparam logic [1:0] REG_MUTE_PERIOD  = 2'd1;
  localparam logic [1:0] REG_RAMP_STEP    = 2'd2;

  // Reset values.
  localparam logic [15:0] FADER_PERIOD_RST = 16'd40;
  localparam logic [15:0] MUTE_PERIOD_RST  = 16'd100;
  localparam logic [16:0] RAMP_STEP_RST    = 17'd3277;
  localparam logic [31:0] NOISE_SEED       = 32'h0000_5EED;

  // Fixed point constants.
  localparam logic [16:0] Q16_ONE   = 17'd65536;
  localparam logic [16:0] TIMER_MAX = 17'h1FFFF;

  // Result kinds.
  localparam logic KIND_FADER = 1'b0;
  localparam logic KIND_MUTE  = 1'b1;

  // One step of the xorshift32 generator.
  function automatic logic [31:0] xorshift32(input logic [31:0] x);
    logic [31:0] a;
    logic [31:0] b;
    begin
      a = x ^ (x << 13);
      b = a ^ (a >> 17);
      return b ^ (b << 5);
    end
  endfunction

endpackage

// ----- rtl/fader_mute_test_pattern_generator_core.sv -----
// ----------------------------------------------------------------------------
// Fader and mute test pattern generator
// Emits fader level ramps and pseudo-random mute states on millisecond ticks.
// ----------------------------------------------------------------------------
// Each input transfer reports the milliseconds since the previous one. The
// first transfer after reset only arms the timers. When the fader period
// has elapsed, every fader ramp advances and one level result per fader is
// sent; when the mute period has elapsed, one mute result per mute channel
// follows. The final result of a transfer has last set. An item is accepted,
// its timers are checked, and then the slot sequencer issues one fader or mute
// channel per cycle while the output does not stall, into a four-stage pipeline
// (ramp memory read, ramp update and write-back, multiply, level rounding),
// which then drains before the next item is taken. The ramps live in a small
// memory whose entries read as zero until first written.
module fader_mute_test_pattern_generator_core (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fmtpg_pkg::ADDR_W-1:0]  paddr,
  input  logic [fmtpg_pkg::DATA_W-1:0]  pwdata,
  output logic [fmtpg_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  // Input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [15:0]                   elapsed_ms,
  // Output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          kind,
  output logic [4:0]                    channel,
  output logic [16:0]                   level,
  output logic                          muted,
  output logic                          last
);

  import fmtpg_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_TIMER = 4'b0010,
    ST_RUN   = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  // Configuration registers.
  logic [15:0] fader_period_ms;
  logic [15:0] mute_period_ms;
  logic [16:0] ramp_step;
  logic        cfg_write;

  // Control state.
  state_t      state;
  logic        first_item;
  logic [16:0] fader_timer;
  logic [16:0] mute_timer;
  logic [31:0] noise_state;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] fader_slots;
  logic [SLOT_W-1:0] total_slots;
  logic [SLOT_W-1:0] last_slot;
  logic [FADER_COUNT-1:0] ramp_valid;

  // Timer arithmetic.
  logic [17:0] fader_sum;
  logic [17:0] mute_sum;
  logic        fader_fire;
  logic        mute_fire;
  logic [SLOT_W-1:0] fader_slots_next;
  logic [SLOT_W-1:0] total_slots_next;

  // Pipeline stages.
  logic        adv;
  logic        issue;
  logic        issue_kind;
  logic [SLOT_W-1:0] mute_index;
  logic [4:0]  issue_channel;
  logic        s1_valid;
  logic        s1_kind;
  logic        s1_keep;
  logic        s1_last;
  logic [4:0]  s1_channel;
  logic        s1_ramp_valid;
  logic        s2_valid;
  logic        s2_kind;
  logic        s2_last;
  logic [4:0]  s2_channel;
  logic signed [17:0] s2_ramp;
  logic        s2_muted;
  logic        s3_valid;
  logic        s3_kind;
  logic        s3_last;
  logic [4:0]  s3_channel;
  logic signed [35:0] s3_prod;
  logic        s3_muted;

  // Ramp memory.
  logic [17:0] ram_rdata;
  logic        ram_we;
  logic signed [17:0] ramp_cur;
  logic signed [18:0] ramp_sum;
  logic signed [18:0] ramp_wrapped;
  logic signed [17:0] ramp_new;
  logic [31:0] noise_next;

  // Level arithmetic.
  logic [16:0] ramp_abs;
  logic [16:0] one_minus;
  logic signed [37:0] level_acc;
  logic [17:0] level_raw;
  logic [16:0] level_sat;

  // --------------------------------------------------------------------------
  // Configuration port: writes take effect at the access phase.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      fader_period_ms <= FADER_PERIOD_RST;
      mute_period_ms  <= MUTE_PERIOD_RST;
      ramp_step       <= RAMP_STEP_RST;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_FADER_PERIOD: fader_period_ms <= pwdata[15:0];
        REG_MUTE_PERIOD:  mute_period_ms  <= pwdata[15:0];
        REG_RAMP_STEP:    ramp_step       <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FADER_PERIOD: prdata = {16'd0, fader_period_ms};
      REG_MUTE_PERIOD:  prdata = {16'd0, mute_period_ms};
      REG_RAMP_STEP:    prdata = {15'd0, ramp_step};
      default:          prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Timer accumulation with saturation, then the period check in the timer state.
  assign fader_sum  = {1'b0, fader_timer} + {2'b00, elapsed_ms};
  assign mute_sum   = {1'b0, mute_timer} + {2'b00, elapsed_ms};
  assign fader_fire = fader_timer >= {1'b0, fader_period_ms};
  assign mute_fire  = mute_timer >= {1'b0, mute_period_ms};

  assign fader_slots_next = fader_fire ? SLOT_W'(FADER_COUNT) : '0;
  assign total_slots_next = fader_slots_next + (mute_fire ? SLOT_W'(MUTE_COUNT) : '0);

  // --------------------------------------------------------------------------
  // Sequencer: accepts an item, checks the timers, then issues one slot per
  // cycle while the pipeline advances.
  assign in_stall = (state != ST_IDLE);
  assign adv      = !out_valid || !out_stall;
  assign issue    = (state == ST_RUN) && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      first_item  <= 1'b1;
      fader_timer <= '0;
      mute_timer  <= '0;
      slot        <= '0;
      fader_slots <= '0;
      total_slots <= '0;
      last_slot   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (first_item) begin
              first_item  <= 1'b0;
              fader_timer <= '0;
              mute_timer  <= '0;
            end else begin
              fader_timer <= fader_sum[17] ? TIMER_MAX : fader_sum[16:0];
              mute_timer  <= mute_sum[17] ? TIMER_MAX : mute_sum[16:0];
              state       <= ST_TIMER;
            end
          end
        end
        ST_TIMER: begin
          if (fader_fire) begin
            fader_timer <= fader_timer - {1'b0, fader_period_ms};
          end
          if (mute_fire) begin
            mute_timer <= mute_timer - {1'b0, mute_period_ms};
          end
          slot        <= '0;
          fader_slots <= fader_slots_next;
          total_slots <= total_slots_next;
          last_slot   <= (total_slots_next > SLOT_W'(MAX_RESULTS)) ?
                         SLOT_W'(MAX_RESULTS - 1) : total_slots_next - 1'b1;
          state       <= (total_slots_next == '0) ? ST_IDLE : ST_RUN;
        end
        ST_RUN: begin
          if (adv) begin
            slot <= slot + 1'b1;
            if (slot == total_slots - 1'b1) begin
              state <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (!s1_valid && !s2_valid && !s3_valid) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Slot decode: faders come first, then mute channels.
  assign issue_kind    = (slot < fader_slots) ? KIND_FADER : KIND_MUTE;
  assign mute_index    = slot - fader_slots;
  assign issue_channel = (issue_kind == KIND_FADER) ? slot[4:0] : mute_index[4:0];

  // --------------------------------------------------------------------------
  // Ramp memory; an entry reads as zero until its first write-back.
  fmtpg_ram #(
    .WIDTH (18),
    .DEPTH (FADER_COUNT)
  ) u_ramp_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_channel[FADER_AW-1:0]),
    .wdata (ramp_new),
    .re    (issue),
    .raddr (slot[FADER_AW-1:0]),
    .rdata (ram_rdata)
  );

  // Stage 1 control: the slot that was just read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_kind       <= issue_kind;
      s1_channel    <= issue_channel;
      s1_keep       <= slot < SLOT_W'(MAX_RESULTS);
      s1_last       <= slot == last_slot;
      s1_ramp_valid <= ramp_valid[slot[FADER_AW-1:0]];
    end
  end

  // Stage 1 work: ramp advance with wrap, or one generator step.
  assign ramp_cur     = s1_ramp_valid ? signed'(ram_rdata) : '0;
  assign ramp_sum     = 19'(ramp_cur) + signed'({2'b00, ramp_step});
  assign ramp_wrapped = (ramp_sum > 19'sd65536) ? ramp_sum - 19'sd131072 : ramp_sum;
  assign ramp_new     = ramp_wrapped[17:0];
  assign ram_we       = adv && s1_valid && (s1_kind == KIND_FADER);
  assign noise_next   = xorshift32(noise_state);

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_valid  <= '0;
      noise_state <= NOISE_SEED;
    end else begin
      if (ram_we) begin
        ramp_valid[s1_channel[FADER_AW-1:0]] <= 1'b1;
      end
      if (adv && s1_valid && (s1_kind == KIND_MUTE)) begin
        noise_state <= noise_next;
      end
    end
  end

  // Stage 2: dropped slots leave the pipeline here.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && s1_keep;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_kind    <= s1_kind;
      s2_last    <= s1_last;
      s2_channel <= s1_channel;
      s2_ramp    <= ramp_new;
      s2_muted   <= noise_next[15];
    end
  end

  // Stage 3: product r * (1 - |r|) in Q0.32.
  assign ramp_abs  = s2_ramp[17] ? 17'(-s2_ramp) : s2_ramp[16:0];
  assign one_minus = Q16_ONE - ramp_abs;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_kind    <= s2_kind;
      s3_last    <= s2_last;
      s3_channel <= s2_channel;
      s3_prod    <= s2_ramp * signed'({1'b0, one_minus});
      s3_muted   <= s2_muted;
    end
  end

  // Level: 2p + 0.5 with half-LSB rounding, clamped to one.
  assign level_acc = (38'(s3_prod) <<< 1) + 38'sh0_8000_8000;
  assign level_raw = level_acc[33:16];
  assign level_sat = (level_raw > {1'b0, Q16_ONE}) ? Q16_ONE : level_raw[16:0];

  // --------------------------------------------------------------------------
  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind    <= s3_kind;
      channel <= s3_channel;
      level   <= (s3_kind == KIND_FADER) ? level_sat : '0;
      muted   <= (s3_kind == KIND_MUTE) ? s3_muted : 1'b0;
      last    <= s3_last;
    end
  end

  // --------------------------------------------------------------------------
  // Checks.
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!s1_valid && !s2_valid && !s3_valid))
    else $error("Pipeline holds work while the sequencer is idle.");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (slot < total_slots))
    else $error("Slot counter ran past the slot count.");

  a_issue_from_run: assert property (@(posedge clk) disable iff (rst)
    $rose(s1_valid) |-> $past(state == ST_RUN))
    else $error("A slot entered the pipeline outside the run state.");

  a_level_form: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((level <= Q16_ONE) && ((kind == KIND_FADER) || (level == '0))
                   && ((kind == KIND_MUTE) || !muted)))
    else $error("Result fields do not match the result kind.");

endmodule

// ----- rtl/fmtpg_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fmtpg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // The write lands in the array; the read data register holds when re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
